// ----- rtl/ptm_pkg.sv -----
// shared types, codes and constants of the page table mapper
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

    localparam int TABLE_FRAMES_DEF = 64;
    localparam int IDX_W            = 9;
    localparam int ENTRIES          = 512;
    localparam int PN_W             = 40;
    localparam int S_DATA_W         = 168;
    localparam int M_DATA_W         = 88;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] OP_MAP_4K = 2'd0;
    localparam logic [1:0] OP_MAP_2M = 2'd1;
    localparam logic [1:0] OP_MAP_1G = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_TABLE = 2'd1;
    localparam logic [1:0] STS_OUTSIDE  = 2'd2;

    localparam logic [51:0] MASK_4K   = 52'hF_FFFF_FFFF_F000;
    localparam logic [51:0] MASK_2M   = 52'hF_FFFF_FFE0_0000;
    localparam logic [51:0] MASK_1G   = 52'hF_FFFF_C000_0000;
    localparam logic [63:0] HUGE_BIT  = 64'h80;
    localparam logic [11:0] LINK_BITS = 12'h007;

    // one decoded mapping request
    typedef struct packed {
        logic [2:0][IDX_W-1:0] walk_idx;
        logic [1:0]            walks;
        logic [IDX_W-1:0]      leaf_idx;
        logic [63:0]           leaf_value;
    } cmd_t;

    typedef struct packed {
        logic [6:0]       tables_used;
        logic [63:0]      leaf_value;
        logic [IDX_W-1:0] leaf_index;
        logic [5:0]       leaf_table;
        logic [1:0]       status;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/page_table_mapper.sv -----
// page table mapper: four-level map engine over a local table store
// path: queue, one table read per walked level, leaf write, then the result register
// the walker takes a new request only after the last result is registered
// allocating a table that was written before it was handed out first wipes its 512 entries
// reset: the store is swept to zero, with s_tready low until the sweep ends
// reset also sets the allocator to one table in use and base_reg to zero
`timescale 1ns / 1ps
`default_nettype none

module page_table_mapper
    import ptm_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PN_W-1:0]     cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // operation[1:0], vaddr[49:2], frame_address[101:50], entry_flags[165:102]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], leaf_table[7:2], leaf_index[16:8], leaf_value[80:17], tables_used[87:81]
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic [PN_W-1:0] base_reg;
    logic            walker_ready;
    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    cmd_t            push_cmd;
    cmd_t            head_cmd;
    res_t            result;

    assign cfg_ready = 1'b1;
    assign m_tdata   = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    ptm_front u_front (
        .enable   (walker_ready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    ptm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    ptm_walker #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .base     (base_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .pop      (pop),
        .ready    (walker_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- rtl/ptm_front.sv -----
// request decoder: splits the address into walk indices and builds the leaf entry
`timescale 1ns / 1ps
`default_nettype none

module ptm_front
    import ptm_pkg::*;
(
    input  wire logic                enable,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                q_full,
    output logic                     push,
    output cmd_t                     cmd
);

    logic [1:0]  op;
    logic [47:0] va;
    logic [51:0] frame;
    logic [63:0] flags;
    logic [IDX_W-1:0] idx3;

    assign s_tready = enable & ~q_full;
    assign push     = s_tvalid & s_tready;

    always_comb
    begin
        op    = s_tdata[1:0];
        va    = s_tdata[49:2];
        frame = s_tdata[101:50];
        flags = s_tdata[165:102];
        // unused code maps as 1G
        if (op == 2'd3)
        begin
            op = OP_MAP_1G;
        end
        idx3 = va[20:12];
        cmd.walk_idx[0] = va[47:39];
        cmd.walk_idx[1] = va[38:30];
        cmd.walk_idx[2] = va[29:21];
        cmd.walks = 2'd3 - op;
        case (op)
            OP_MAP_4K:
            begin
                cmd.leaf_idx   = idx3;
                cmd.leaf_value = {12'd0, frame & MASK_4K} | flags;
            end
            OP_MAP_2M:
            begin
                cmd.leaf_idx   = va[29:21];
                cmd.leaf_value = {12'd0, frame & MASK_2M} | flags | HUGE_BIT;
            end
            default:
            begin
                cmd.leaf_idx   = va[38:30];
                cmd.leaf_value = {12'd0, frame & MASK_1G} | flags | HUGE_BIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ptm_queue.sv -----
// short command queue between the decoder and the table walker
`timescale 1ns / 1ps
`default_nettype none

module ptm_queue
    import ptm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ptm_walker.sv -----
// table walker: owns the table store, allocator and result register
`timescale 1ns / 1ps
`default_nettype none

module ptm_walker
    import ptm_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [PN_W-1:0] base,
    input  wire logic            q_valid,
    input  cmd_t                 q_cmd,
    output logic                 pop,
    output logic                 ready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output res_t                 result
);

    localparam int TW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NFW   = $clog2(TABLE_FRAMES + 1);
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SWEEP,
        S_LINK,
        S_LEAF,
        S_DONE
    } state_t;

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [TW-1:0]     table_reg, table_next;
    logic [TW-1:0]     child_reg, child_next;
    logic [NFW-1:0]    nf_reg, nf_next;
    logic [TABLE_FRAMES-1:0] dirty_reg, dirty_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]  sweep_reg, sweep_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [63:0]       link_reg, link_next;
    logic [1:0]        status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic              wr_user;
    logic [AW-1:0]     wr_addr;
    logic [63:0]       wr_data;
    logic [AW-1:0]     cur_slot;
    logic [PN_W-1:0]   ptr_ofs;
    logic [PN_W-1:0]   alloc_pn;
    logic [TW-1:0]     wr_tbl;

    assign ready    = (state_reg != S_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign result   = res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lvl_next       = lvl_reg;
        table_next     = table_reg;
        child_next     = child_reg;
        nf_next        = nf_reg;
        dirty_next     = dirty_reg;
        clr_cnt_next   = clr_cnt_reg;
        sweep_next     = sweep_reg;
        slot_next      = slot_reg;
        link_next      = link_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = {table_reg, cmd_reg.walk_idx[lvl_reg]};
        wr_en          = 1'b0;
        wr_user        = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = '0;
        cur_slot       = {table_reg, cmd_reg.walk_idx[lvl_reg]};
        ptr_ofs        = rd_data_reg[51:12] - base;
        alloc_pn       = base + PN_W'(nf_reg);

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    cmd_next    = q_cmd;
                    lvl_next    = '0;
                    table_next  = '0;
                    status_next = STS_OK;
                    rd_en       = 1'b1;
                    rd_addr     = {TW'(0), q_cmd.walk_idx[0]};
                    state_next  = S_EVAL;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (rd_data_reg == '0)
                begin
                    if (nf_reg >= NFW'(TABLE_FRAMES))
                    begin
                        status_next = STS_NO_TABLE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        child_next = nf_reg[TW-1:0];
                        nf_next    = nf_reg + 1'b1;
                        slot_next  = cur_slot;
                        link_next  = {12'd0, alloc_pn, LINK_BITS};
                        if (dirty_reg[nf_reg[TW-1:0]])
                        begin
                            // table was written through a stray pointer: wipe it first
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_user    = 1'b1;
                            wr_addr    = cur_slot;
                            wr_data    = {12'd0, alloc_pn, LINK_BITS};
                            table_next = nf_reg[TW-1:0];
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = (lvl_reg + 1'b1 == cmd_reg.walks) ? S_LEAF : S_READ;
                        end
                    end
                end
                else if (ptr_ofs >= PN_W'(TABLE_FRAMES))
                begin
                    status_next = STS_OUTSIDE;
                    state_next  = S_DONE;
                end
                else
                begin
                    table_next = ptr_ofs[TW-1:0];
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = (lvl_reg + 1'b1 == cmd_reg.walks) ? S_LEAF : S_READ;
                end
            end
            S_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = {child_reg, sweep_reg};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == IDX_W'(ENTRIES - 1))
                begin
                    dirty_next[child_reg] = 1'b0;
                    state_next            = S_LINK;
                end
            end
            S_LINK:
            begin
                wr_en      = 1'b1;
                wr_user    = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = link_reg;
                table_next = child_reg;
                lvl_next   = lvl_reg + 1'b1;
                state_next = (lvl_reg + 1'b1 == cmd_reg.walks) ? S_LEAF : S_READ;
            end
            S_LEAF:
            begin
                wr_en      = 1'b1;
                wr_user    = 1'b1;
                wr_addr    = {table_reg, cmd_reg.leaf_idx};
                wr_data    = cmd_reg.leaf_value;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.tables_used = 7'(nf_reg);
                    if (status_reg == STS_OK)
                    begin
                        res_next.leaf_table = 6'(table_reg);
                        res_next.leaf_index = cmd_reg.leaf_idx;
                        res_next.leaf_value = cmd_reg.leaf_value;
                    end
                    else
                    begin
                        res_next.leaf_table = '0;
                        res_next.leaf_index = '0;
                        res_next.leaf_value = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writes into a table not yet handed out must be wiped when it is allocated
        wr_tbl = wr_addr[AW-1:IDX_W];
        if (wr_user && (NFW'(wr_tbl) >= nf_next))
        begin
            dirty_next[wr_tbl] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            nf_reg        <= NFW'(1);
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            lvl_reg       <= '0;
            table_reg     <= '0;
            child_reg     <= '0;
            sweep_reg     <= '0;
            slot_reg      <= '0;
            link_reg      <= '0;
            status_reg    <= STS_OK;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nf_reg        <= nf_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            lvl_reg       <= lvl_next;
            table_reg     <= table_next;
            child_reg     <= child_next;
            sweep_reg     <= sweep_next;
            slot_reg      <= slot_next;
            link_reg      <= link_next;
            status_reg    <= status_next;
            res_reg       <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_page_table_mapper.sv -----
// self-checking testbench for the page table mapper with a software page walk predictor
`timescale 1ns / 1ps

module tb_page_table_mapper;
    import ptm_pkg::*;

    localparam int TBL_FRAMES  = TABLE_FRAMES_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 330;

    localparam logic [1:0]  OP_SPARE  = 2'd3;
    localparam logic [39:0] BASE_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] BASE_ZERO = 40'h0;

    // packed like s_tdata, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic [63:0] flags;
        logic [51:0] frame;
        logic [47:0] va;
        logic [1:0]  op;
    } map_req_t;

    typedef struct {
        map_req_t req;
        bit       typed;
        res_t     want;
    } probe_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PN_W-1:0]     cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    // operation[1:0], vaddr[49:2], frame_address[101:50], entry_flags[165:102]
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // status[1:0], leaf_table[7:2], leaf_index[16:8], leaf_value[80:17], tables_used[87:81]
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state
    logic [63:0] walk_mem [0:TBL_FRAMES*ENTRIES-1];
    int unsigned next_tbl;
    logic [39:0] tbl_base;

    res_t        pending_maps[$];
    probe_t      probes[$];
    int          mismatches;
    int          snd_idle;
    int          rcv_idle;
    bit          hold_off_req;

    page_table_mapper #(
        .TABLE_FRAMES(TBL_FRAMES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic map_req_t mk_req(input logic [1:0] op, input logic [47:0] va,
                                        input logic [51:0] frame, input logic [63:0] flags);
        map_req_t r;
        r = '0;
        r.op = op;
        r.va = va;
        r.frame = frame;
        r.flags = flags;
        return r;
    endfunction

    function automatic res_t mk_res(input logic [1:0] st, input logic [5:0] tbl,
                                    input logic [8:0] idx, input logic [63:0] val,
                                    input logic [6:0] used);
        res_t o;
        o.status = st;
        o.leaf_table = tbl;
        o.leaf_index = idx;
        o.leaf_value = val;
        o.tables_used = used;
        return o;
    endfunction

    // one level of the walk: follow or allocate the entry at tbl/idx
    function automatic logic [1:0] walk_level(input int unsigned tbl, input logic [8:0] idx,
                                              output int unsigned child);
        int unsigned slot;
        int unsigned n;
        logic [63:0] e;
        logic [39:0] pn;
        logic [39:0] ptr_ofs;
        slot = tbl * ENTRIES + idx;
        e = walk_mem[slot];
        child = 0;
        if (e == 64'h0)
        begin
            if (next_tbl >= TBL_FRAMES)
                return STS_NO_TABLE;
            n = next_tbl;
            next_tbl++;
            for (int k = 0; k < ENTRIES; k++)
                walk_mem[n * ENTRIES + k] = 64'h0;
            pn = tbl_base + 40'(n);
            walk_mem[slot] = {12'h0, pn, LINK_BITS};
            child = n;
            return STS_OK;
        end
        // any non-zero entry is taken as a pointer, huge leaves included
        pn = e[51:12];
        ptr_ofs = pn - tbl_base;
        if (ptr_ofs >= 40'(TBL_FRAMES))
            return STS_OUTSIDE;
        child = ptr_ofs[31:0];
        return STS_OK;
    endfunction

    function automatic res_t predict_mapping(input map_req_t r);
        res_t        o;
        logic [1:0]  op;
        logic [1:0]  st;
        logic [8:0]  lvl_idx [4];
        logic [63:0] val;
        int unsigned walks;
        int unsigned tbl;
        int unsigned child;
        op = (r.op == OP_SPARE) ? OP_MAP_1G : r.op;
        lvl_idx[0] = r.va[47:39];
        lvl_idx[1] = r.va[38:30];
        lvl_idx[2] = r.va[29:21];
        lvl_idx[3] = r.va[20:12];
        walks = 3 - int'(op);
        st = STS_OK;
        tbl = 0;
        for (int l = 0; l < walks && st == STS_OK; l++)
        begin
            st = walk_level(tbl, lvl_idx[l], child);
            if (st == STS_OK)
                tbl = child;
        end
        o = '0;
        o.status = st;
        o.tables_used = 7'(next_tbl);
        if (st == STS_OK)
        begin
            case (op)
                OP_MAP_4K: val = {12'h0, r.frame & MASK_4K} | r.flags;
                OP_MAP_2M: val = {12'h0, r.frame & MASK_2M} | r.flags | HUGE_BIT;
                default:   val = {12'h0, r.frame & MASK_1G} | r.flags | HUGE_BIT;
            endcase
            walk_mem[tbl * ENTRIES + lvl_idx[walks]] = val;
            o.leaf_table = 6'(tbl);
            o.leaf_index = lvl_idx[walks];
            o.leaf_value = val;
        end
        return o;
    endfunction

    // mostly walks over a small set of paths so tables get reused, the rest is noise
    function automatic map_req_t random_req();
        logic [1:0]  op;
        logic [47:0] va;
        logic [51:0] frame;
        logic [63:0] flags;
        logic [8:0]  roots [6];
        logic [8:0]  mids [2];
        op = 2'($urandom_range(0, 3));
        va = 48'({$urandom(), $urandom()});
        frame = 52'({$urandom(), $urandom()});
        flags = {$urandom(), $urandom()};
        if ($urandom_range(0, 99) < 75)
        begin
            roots = '{9'h000, 9'h1FF, 9'h001, 9'h1FE, 9'h002, 9'h1FD};
            mids = '{9'h000, 9'h1FF};
            op = ($urandom_range(0, 19) == 0) ? OP_SPARE : 2'($urandom_range(0, 2));
            va[47:39] = roots[(op == OP_SPARE ? 4 : 2 * int'(op)) + $urandom_range(0, 1)];
            va[38:30] = mids[$urandom_range(0, 1)];
            va[29:21] = mids[$urandom_range(0, 1)];
            // small flags clear flag bits 62:12, so only the frame sets the pointer bits of such a leaf
            if ($urandom_range(0, 1) == 1)
                flags = {flags[63], 51'h0, flags[11:0]};
        end
        return mk_req(op, va, frame, flags);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 200)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", what, got, want));
    endtask

    task automatic push_map(input map_req_t r, input bit typed, input res_t typed_res);
        res_t pred;
        @(negedge clk);
        if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        do @(posedge clk); while (!s_tready);
        pred = predict_mapping(r);
        pending_maps.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [39:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        tbl_base = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result receiver with random backpressure and one long hold-off
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_maps.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end
            else
            begin
                want = pending_maps.pop_front();
                check_field("status", 64'(got.status), 64'(want.status));
                check_field("leaf_table", 64'(got.leaf_table), 64'(want.leaf_table));
                check_field("leaf_index", 64'(got.leaf_index), 64'(want.leaf_index));
                check_field("leaf_value", got.leaf_value, want.leaf_value);
                check_field("tables_used", 64'(got.tables_used), 64'(want.tables_used));
            end
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [39:0] phase_base [3];
        int          phase_snd [3];
        int          phase_rcv [3];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        snd_idle = 0;
        rcv_idle = 0;
        hold_off_req = 1'b0;
        for (int i = 0; i < TBL_FRAMES * ENTRIES; i++)
            walk_mem[i] = 64'h0;
        next_tbl = 1;
        tbl_base = BASE_ZERO;

        // base at its top value, so table 1 sits at physical page zero
        probes.push_back('{mk_req(OP_MAP_4K, 48'h0, 52'hF_FFFF_FFFF_FFFF, 64'h0), 1'b1,
            mk_res(STS_OK, 6'd3, 9'd0, 64'h000F_FFFF_FFFF_F000, 7'd4)});
        probes.push_back('{mk_req(OP_MAP_2M, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 64'h0),
            1'b1, mk_res(STS_OK, 6'd5, 9'd511, 64'h000F_FFFF_FFE0_0080, 7'd6)});
        probes.push_back('{mk_req(OP_MAP_1G, 48'h0000_4000_0000, 52'h0, 64'hFFFF_FFFF_FFFF_FFFF),
            1'b1, mk_res(STS_OK, 6'd1, 9'd1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd6)});
        // spare op code behaves as 1G
        probes.push_back('{mk_req(OP_SPARE, 48'h0000_8000_0000, 52'h0_0000_7FFF_FFFF, 64'h0),
            1'b1, mk_res(STS_OK, 6'd1, 9'd2, 64'h0000_0000_4000_0080, 7'd6)});
        // all-ones 1G leaf read as a pointer lands back on the root
        probes.push_back('{mk_req(OP_MAP_4K, 48'h0000_4000_5000, 52'h0_0000_1234_5678, 64'h1),
            1'b0, '0});
        // 2M leaf read as a pointer falls outside the store
        probes.push_back('{mk_req(OP_MAP_4K, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0), 1'b1,
            mk_res(STS_OUTSIDE, 6'd0, 9'd0, 64'h0, 7'd6)});
        probes.push_back('{mk_req(OP_MAP_2M, 48'h0000_8060_0000, 52'h0, 64'h0), 1'b0, '0});
        probes.push_back('{mk_req(OP_MAP_4K, 48'h0000_0000_7000, 52'hA_BCDE_F012_3456,
            64'h8000_0000_0000_0003), 1'b1,
            mk_res(STS_OK, 6'd3, 9'd7, 64'h800A_BCDE_F012_3003, 7'd6)});
        probes.push_back('{mk_req(OP_MAP_2M, 48'h0000_0020_0000, 52'h0, 64'h0), 1'b1,
            mk_res(STS_OK, 6'd2, 9'd1, 64'h80, 7'd6)});
        probes.push_back('{mk_req(OP_MAP_1G, 48'h8000_0000_0000, 52'hF_FFFF_FFFF_FFFF, 64'h0),
            1'b1, mk_res(STS_OK, 6'd6, 9'd0, 64'h000F_FFFF_C000_0080, 7'd7)});
        probes.push_back('{mk_req(OP_MAP_4K, 48'h5555_5555_5555, 52'h5_5555_5555_5555,
            64'h5555_5555_5555_5555), 1'b0, '0});
        probes.push_back('{mk_req(OP_MAP_4K, 48'hAAAA_AAAA_AAAA, 52'hA_AAAA_AAAA_AAAA,
            64'hAAAA_AAAA_AAAA_AAAA), 1'b0, '0});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_base(BASE_MAX);
        foreach (probes[i])
            push_map(probes[i].req, probes[i].typed, probes[i].want);
        drain_results();

        phase_base = '{BASE_ZERO, 40'($urandom_range(1, 48)), BASE_ZERO};
        phase_snd = '{33, 72, 0};
        phase_rcv = '{72, 33, 0};
        for (int p = 0; p < 3; p++)
        begin
            snd_idle = phase_snd[p];
            rcv_idle = phase_rcv[p];
            // last phase: long output stall while requests keep coming
            if (p == 2)
                hold_off_req = 1'b1;
            write_base(phase_base[p]);
            repeat (RAND_ITEMS)
                push_map(random_req(), 1'b0, '0);
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ptm_pkg.sv
rtl/ptm_front.sv
rtl/ptm_queue.sv
rtl/ptm_walker.sv
rtl/page_table_mapper.sv
sim/tb_page_table_mapper.sv
